FILE: design/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and helpers for the rgb fade cycle generator.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int TIME_BITS = 48;
    localparam int COLOR_W   = 24;
    localparam int MS_W      = 16;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int US_PER_MS = 1000;
    // (2^TIME_BITS - 1) / 1000 fits below 2^(TIME_BITS - 9)
    localparam int PROG_W    = TIME_BITS - 9;
    localparam int NUM_W     = CH_W + MS_W;
    localparam int PROD_W    = MS_W + 10;
    localparam int DIV_CNT_W = $clog2(TIME_BITS + 1);
    localparam int ADDR_W    = 5;
    localparam int APB_W     = 32;

    localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_PAUSE,
        OP_STOP
    } t_op;

    typedef enum logic [2:0] {
        REG_ON_COLOR,
        REG_OFF_COLOR,
        REG_FADE_IN_TIME,
        REG_HOLD_TIME,
        REG_FADE_OUT_TIME,
        REG_CYCLE_LENGTH
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_MS,
        S_MOD,
        S_ANCHOR,
        S_PHASE,
        S_MUL_A,
        S_MUL_B,
        S_DIV_CH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] dividend;
        logic [MS_W-1:0]      divisor;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_ctl;

    typedef struct packed {
        logic                 done;
        logic [TIME_BITS-1:0] quot;
        logic [MS_W-1:0]      rem;
    } t_div_sts;

    // channel 0 is red in the top byte
    function automatic logic [CH_W-1:0] chan_get(input logic [COLOR_W-1:0] color,
                                                 input logic [1:0] ch);
        logic [CH_W-1:0] v;
        case (ch)
            2'd0:    v = color[23:16];
            2'd1:    v = color[15:8];
            default: v = color[7:0];
        endcase
        return v;
    endfunction

endpackage

FILE: design/rgb_fade_cycle_generator_core.sv
// ----------------------------------------------------------------------------
// rgb_fade_cycle_generator_core
// Heartbeat-synchronised rgb fade cycle: fade, hold, fade back.
// ----------------------------------------------------------------------------
// a tick divides the elapsed time down to ms, wraps it by the cycle length when
// needed, and in a fade blends each colour channel with a multiply and a divide
// throughput: one item at a time, taken only in idle; the shared bit-serial divider
// (48 bits for the ms count, 39 for the wrap, 24 per colour channel) does the work
// reset: synchronous, active low; config registers to defaults, control state cleared
module rgb_fade_cycle_generator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [55:0]                  i_s_axis_tdata,  // heartbeat[7:0], now_us[55:8]
    input  logic [1:0]                   i_s_axis_tuser,  // op[1:0]
    // output stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [23:0]                  o_m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rfc_pkg::APB_W-1:0]    pwdata,
    output logic [rfc_pkg::APB_W-1:0]    prdata,
    output logic                         pready
);

    localparam logic [rfc_pkg::DIV_CNT_W-1:0] TB =
        rfc_pkg::DIV_CNT_W'(rfc_pkg::TIME_BITS);

    // configuration registers
    logic [rfc_pkg::COLOR_W-1:0] r_on, r_off;
    logic [rfc_pkg::MS_W-1:0]    r_fi, r_hold, r_fo, r_cl;

    // control state
    rfc_pkg::t_state             r_state, n_state;
    logic                        r_running, n_running;
    logic                        r_paused, n_paused;
    logic [7:0]                  r_last_hb, n_last_hb;
    logic [rfc_pkg::TIME_BITS-1:0] r_cycle_start, n_cycle_start;
    logic                        r_out_valid, n_out_valid;

    // working registers
    rfc_pkg::t_op                r_op, n_op;
    logic [7:0]                  r_hb, n_hb;
    logic [rfc_pkg::TIME_BITS-1:0] r_now, n_now;
    logic [rfc_pkg::MS_W-1:0]    r_p, n_p;
    logic [rfc_pkg::COLOR_W-1:0] r_from, n_from, r_to, n_to, r_rgb, n_rgb;
    logic [rfc_pkg::MS_W-1:0]    r_el, n_el, r_tot, n_tot;
    logic [1:0]                  r_ch, n_ch;
    logic [rfc_pkg::NUM_W-1:0]   r_acc, n_acc;
    logic [rfc_pkg::COLOR_W-1:0] r_out_data, n_out_data;

    rfc_pkg::t_div_ctl           w_div_ctl;
    rfc_pkg::t_div_sts           w_div_sts;

    logic                        w_accept, w_cfg_wr, w_out_space;
    logic [rfc_pkg::TIME_BITS-1:0] w_diff;
    logic [rfc_pkg::PROG_W-1:0]  w_prog;
    logic [rfc_pkg::MS_W-1:0]    w_len;
    logic                        w_wrap;
    logic [rfc_pkg::PROD_W-1:0]  w_prod;
    logic [rfc_pkg::MS_W:0]      w_fi_hold;
    logic                        w_in_fade1, w_in_hold, w_skip, w_direct;
    logic [rfc_pkg::MS_W-1:0]    w_el, w_tot;
    logic [rfc_pkg::COLOR_W-1:0] w_from, w_to;
    logic [rfc_pkg::NUM_W-1:0]   w_sum;
    logic                        w_run_active;
    rfc_pkg::t_reg_idx           w_reg_idx;

    rfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_sts   (w_div_sts)
    );

    // ---------------- handshakes ----------------
    assign o_s_axis_tready = (r_state == rfc_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_data[7:0], r_out_data[15:8], r_out_data[23:16]};
    assign w_out_space     = !r_out_valid || i_m_axis_tready;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = rfc_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg_idx)
            rfc_pkg::REG_ON_COLOR:      prdata = rfc_pkg::APB_W'(r_on);
            rfc_pkg::REG_OFF_COLOR:     prdata = rfc_pkg::APB_W'(r_off);
            rfc_pkg::REG_FADE_IN_TIME:  prdata = rfc_pkg::APB_W'(r_fi);
            rfc_pkg::REG_HOLD_TIME:     prdata = rfc_pkg::APB_W'(r_hold);
            rfc_pkg::REG_FADE_OUT_TIME: prdata = rfc_pkg::APB_W'(r_fo);
            rfc_pkg::REG_CYCLE_LENGTH:  prdata = rfc_pkg::APB_W'(r_cl);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= 24'hFFFFFF;
            r_off  <= '0;
            r_fi   <= 16'd400;
            r_hold <= 16'd200;
            r_fo   <= 16'd400;
            r_cl   <= 16'd1000;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                rfc_pkg::REG_ON_COLOR:      r_on   <= pwdata[rfc_pkg::COLOR_W-1:0];
                rfc_pkg::REG_OFF_COLOR:     r_off  <= pwdata[rfc_pkg::COLOR_W-1:0];
                rfc_pkg::REG_FADE_IN_TIME:  r_fi   <= pwdata[rfc_pkg::MS_W-1:0];
                rfc_pkg::REG_HOLD_TIME:     r_hold <= pwdata[rfc_pkg::MS_W-1:0];
                rfc_pkg::REG_FADE_OUT_TIME: r_fo   <= pwdata[rfc_pkg::MS_W-1:0];
                rfc_pkg::REG_CYCLE_LENGTH:  r_cl   <= pwdata[rfc_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath helpers ----------------
    always_comb begin
        w_run_active = r_running && !r_paused;
        // a new heartbeat re-anchors at now, so the elapsed time is zero
        w_diff = (r_hb != r_last_hb) ? '0 : (r_now - r_cycle_start);
        w_prog = w_div_sts.quot[rfc_pkg::PROG_W-1:0];
        w_len  = (r_cl == '0) ? rfc_pkg::MS_W'(1) : r_cl;
        w_wrap = (w_prog >= rfc_pkg::PROG_W'(w_len));
        w_prod = rfc_pkg::PROD_W'(r_p) * rfc_pkg::PROD_W'(rfc_pkg::US_PER_MS);

        w_fi_hold  = {1'b0, r_fi} + {1'b0, r_hold};
        w_in_fade1 = (r_p < r_fi);
        w_in_hold  = ({1'b0, r_p} < w_fi_hold);
        if (w_in_fade1) begin
            w_el   = r_p;
            w_tot  = r_fi;
            w_from = r_on;
            w_to   = r_off;
        end else begin
            w_el   = rfc_pkg::MS_W'({1'b0, r_p} - w_fi_hold);
            w_tot  = r_fo;
            w_from = r_off;
            w_to   = r_on;
        end
        w_skip   = (w_tot == '0) || (w_el >= w_tot);
        w_direct = (!w_in_fade1 && w_in_hold) || w_skip;

        w_sum = r_acc + rfc_pkg::NUM_W'(rfc_pkg::chan_get(r_to, r_ch))
                      * rfc_pkg::NUM_W'(r_el);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rfc_pkg::S_IDLE:
                if (w_accept) n_state = rfc_pkg::S_EXEC;
            rfc_pkg::S_EXEC: begin
                case (r_op)
                    rfc_pkg::OP_TICK:
                        n_state = w_run_active ? rfc_pkg::S_DIV_MS : rfc_pkg::S_IDLE;
                    rfc_pkg::OP_START:
                        n_state = w_run_active ? rfc_pkg::S_IDLE : rfc_pkg::S_OUT;
                    rfc_pkg::OP_STOP:
                        n_state = rfc_pkg::S_OUT;
                    default:
                        n_state = rfc_pkg::S_IDLE;
                endcase
            end
            rfc_pkg::S_DIV_MS:
                if (w_div_sts.done) n_state = w_wrap ? rfc_pkg::S_MOD : rfc_pkg::S_PHASE;
            rfc_pkg::S_MOD:
                if (w_div_sts.done) n_state = rfc_pkg::S_ANCHOR;
            rfc_pkg::S_ANCHOR:
                n_state = rfc_pkg::S_PHASE;
            rfc_pkg::S_PHASE:
                n_state = w_direct ? rfc_pkg::S_OUT : rfc_pkg::S_MUL_A;
            rfc_pkg::S_MUL_A:
                n_state = rfc_pkg::S_MUL_B;
            rfc_pkg::S_MUL_B:
                n_state = rfc_pkg::S_DIV_CH;
            rfc_pkg::S_DIV_CH:
                if (w_div_sts.done)
                    n_state = (r_ch == rfc_pkg::CH_LAST) ? rfc_pkg::S_OUT : rfc_pkg::S_MUL_A;
            rfc_pkg::S_OUT:
                if (w_out_space) n_state = rfc_pkg::S_IDLE;
            default:
                n_state = rfc_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_running     = r_running;
        n_paused      = r_paused;
        n_last_hb     = r_last_hb;
        n_cycle_start = r_cycle_start;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_data    = r_out_data;
        n_op          = r_op;
        n_hb          = r_hb;
        n_now         = r_now;
        n_p           = r_p;
        n_from        = r_from;
        n_to          = r_to;
        n_rgb         = r_rgb;
        n_el          = r_el;
        n_tot         = r_tot;
        n_ch          = r_ch;
        n_acc         = r_acc;

        w_div_ctl.start    = 1'b0;
        w_div_ctl.dividend = w_diff;
        w_div_ctl.divisor  = rfc_pkg::MS_W'(rfc_pkg::US_PER_MS);
        w_div_ctl.nbits    = TB;

        case (r_state)
            rfc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op  = rfc_pkg::t_op'(i_s_axis_tuser);
                    n_hb  = i_s_axis_tdata[7:0];
                    n_now = i_s_axis_tdata[55:8];
                end
            end
            rfc_pkg::S_EXEC: begin
                case (r_op)
                    rfc_pkg::OP_TICK: begin
                        if (w_run_active) begin
                            if (r_hb != r_last_hb) begin
                                n_cycle_start = r_now;
                                n_last_hb     = r_hb;
                            end
                            w_div_ctl.start = 1'b1;
                        end
                    end
                    rfc_pkg::OP_START: begin
                        if (!w_run_active) begin
                            n_running     = 1'b1;
                            n_paused      = 1'b0;
                            n_last_hb     = r_hb;
                            n_cycle_start = r_now;
                            n_rgb         = r_on;
                        end
                    end
                    rfc_pkg::OP_PAUSE: begin
                        if (r_running) n_paused = 1'b1;
                    end
                    default: begin
                        n_running     = 1'b0;
                        n_paused      = 1'b0;
                        n_last_hb     = '0;
                        n_cycle_start = '0;
                        n_rgb         = '0;
                    end
                endcase
            end
            rfc_pkg::S_DIV_MS: begin
                if (w_div_sts.done) begin
                    if (w_wrap) begin
                        w_div_ctl.start    = 1'b1;
                        w_div_ctl.dividend = rfc_pkg::TIME_BITS'(w_prog);
                        w_div_ctl.divisor  = w_len;
                        w_div_ctl.nbits    = rfc_pkg::DIV_CNT_W'(rfc_pkg::PROG_W);
                    end else begin
                        n_p = w_prog[rfc_pkg::MS_W-1:0];
                    end
                end
            end
            rfc_pkg::S_MOD: begin
                if (w_div_sts.done) n_p = w_div_sts.rem;
            end
            rfc_pkg::S_ANCHOR: begin
                n_cycle_start = r_now - rfc_pkg::TIME_BITS'(w_prod);
            end
            rfc_pkg::S_PHASE: begin
                n_el   = w_el;
                n_tot  = w_tot;
                n_from = w_from;
                n_to   = w_to;
                n_ch   = '0;
                if (!w_in_fade1 && w_in_hold) begin
                    n_rgb = r_off;
                end else if (w_skip) begin
                    n_rgb = w_to;
                end
            end
            rfc_pkg::S_MUL_A: begin
                n_acc = rfc_pkg::NUM_W'(rfc_pkg::chan_get(r_from, r_ch))
                      * rfc_pkg::NUM_W'(r_tot - r_el);
            end
            rfc_pkg::S_MUL_B: begin
                w_div_ctl.start    = 1'b1;
                w_div_ctl.dividend = rfc_pkg::TIME_BITS'(w_sum);
                w_div_ctl.divisor  = r_tot;
                w_div_ctl.nbits    = rfc_pkg::DIV_CNT_W'(rfc_pkg::NUM_W);
            end
            rfc_pkg::S_DIV_CH: begin
                if (w_div_sts.done) begin
                    case (r_ch)
                        2'd0:    n_rgb[23:16] = w_div_sts.quot[rfc_pkg::CH_W-1:0];
                        2'd1:    n_rgb[15:8]  = w_div_sts.quot[rfc_pkg::CH_W-1:0];
                        default: n_rgb[7:0]   = w_div_sts.quot[rfc_pkg::CH_W-1:0];
                    endcase
                    n_ch = r_ch + 2'd1;
                end
            end
            rfc_pkg::S_OUT: begin
                if (w_out_space) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rgb;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rfc_pkg::S_IDLE;
            r_running     <= 1'b0;
            r_paused      <= 1'b0;
            r_last_hb     <= '0;
            r_cycle_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_running     <= n_running;
            r_paused      <= n_paused;
            r_last_hb     <= n_last_hb;
            r_cycle_start <= n_cycle_start;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_op       <= n_op;
        r_hb       <= n_hb;
        r_now      <= n_now;
        r_p        <= n_p;
        r_from     <= n_from;
        r_to       <= n_to;
        r_rgb      <= n_rgb;
        r_el       <= n_el;
        r_tot      <= n_tot;
        r_ch       <= n_ch;
        r_acc      <= n_acc;
    end

endmodule

FILE: design/rfc_div.sv
// ----------------------------------------------------------------------------
// rfc_div
// Shared restoring divider, one quotient bit per cycle for nbits quotient bits.
// ----------------------------------------------------------------------------
module rfc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfc_pkg::t_div_ctl  i_ctl,
    output rfc_pkg::t_div_sts  o_sts
);

    localparam logic [rfc_pkg::DIV_CNT_W-1:0] TB = rfc_pkg::DIV_CNT_W'(rfc_pkg::TIME_BITS);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [rfc_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [rfc_pkg::TIME_BITS-1:0]   r_q, n_q;
    logic [rfc_pkg::MS_W-1:0]        r_rem, n_rem;
    logic [rfc_pkg::MS_W-1:0]        r_div, n_div;
    logic [rfc_pkg::MS_W:0]          w_trial;
    logic                            w_ge;

    always_comb begin
        w_trial = {r_rem, r_q[rfc_pkg::TIME_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_ctl.start) begin
            // align the dividend to the top so quotient bits shift in below
            n_busy = 1'b1;
            n_cnt  = i_ctl.nbits;
            n_q    = i_ctl.dividend << (TB - i_ctl.nbits);
            n_rem  = '0;
            n_div  = i_ctl.divisor;
        end else if (r_busy) begin
            n_q   = {r_q[rfc_pkg::TIME_BITS-2:0], w_ge};
            n_rem = w_ge ? rfc_pkg::MS_W'(w_trial - {1'b0, r_div})
                         : w_trial[rfc_pkg::MS_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == rfc_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_q;
    assign o_sts.rem  = r_rem;

endmodule
